// ===== src/assert_macros.svh =====
// assertion helpers used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, quiet while reset is held
`define ASC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define ASC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/asc_pkg.sv =====
package asc_pkg;

    // table geometry
    localparam int MAX_SPANS = 64;
    localparam int SLOT_W    = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int HELD_W    = $clog2(MAX_SPANS + 1);

    // fixed field widths
    localparam int ADDR_W       = 64;
    localparam int KIND_W       = 3;
    localparam int SPAN_INDEX_W = 6;
    localparam int SPAN_COUNT_W = 7;
    localparam int STATUS_W     = 2;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // name classes
    localparam logic [2:0] NAME_EMPTY = 3'd0;
    localparam logic [2:0] NAME_HEAP  = 3'd1;
    localparam logic [2:0] NAME_STACK = 3'd2;
    localparam logic [2:0] NAME_PSEUDO = 3'd3;
    localparam logic [2:0] NAME_FILE  = 3'd4;

    // span kinds
    localparam logic [KIND_W-1:0] KIND_HEAP  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STACK = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MMAP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CODE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DATA  = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] span_length;
        logic [2:0]        name_class;
        logic              exec_perm;
        logic              region_unnamed;
    } req_word_t;

    typedef struct packed {
        logic                    hit;
        logic [KIND_W-1:0]       kind;
        logic [ADDR_W-1:0]       span_start;
        logic [ADDR_W-1:0]       extent_length;
        logic [SPAN_INDEX_W-1:0] span_index;
        logic [STATUS_W-1:0]     status;
        logic [SPAN_COUNT_W-1:0] span_count;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_REPLY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic finish;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic query_go;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

    // kind of a span from its name class and execute bit
    function automatic logic [KIND_W-1:0] classify(input logic [2:0] name_class,
                                                   input logic exec_perm);
        logic [KIND_W-1:0] k;
        unique case (name_class)
            NAME_HEAP:  k = KIND_HEAP;
            NAME_STACK: k = KIND_STACK;
            NAME_FILE:  k = exec_perm ? KIND_CODE : KIND_DATA;
            default:    k = KIND_MMAP;
        endcase
        return k;
    endfunction

endpackage

// ===== src/asc_req_if.sv =====
interface asc_req_if;
    import asc_pkg::*;

    logic      valid;
    logic      ready;
    req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/asc_rsp_if.sv =====
interface asc_rsp_if;
    import asc_pkg::*;

    logic      valid;
    logic      ready;
    rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/asc_ctrl.sv =====
module asc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output asc_pkg::ctrl_cmd_t cmd,
    input  asc_pkg::ctrl_sts_t sts
);
    import asc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && in_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.query_go ? ST_SCAN : ST_REPLY;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_REPLY;
            ST_REPLY:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_DRAIN:  cmd           = '0;
            ST_FINISH: cmd.finish    = 1'b1;
            ST_REPLY:  cmd.out_load  = sts.out_free;
            default:   cmd           = '0;
        endcase
    end

endmodule

// ===== src/asc_datapath.sv =====
`include "assert_macros.svh"

module asc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  asc_pkg::req_word_t in_data,
    input  asc_pkg::ctrl_cmd_t cmd,
    output asc_pkg::ctrl_sts_t sts,
    asc_rsp_if.source          rsp
);
    import asc_pkg::*;

    // span table, no reset: only slots below the held count are read
    logic [ADDR_W-1:0] base_mem [MAX_SPANS];
    logic [ADDR_W-1:0] len_mem  [MAX_SPANS];
    logic [KIND_W-1:0] kind_mem [MAX_SPANS];

    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    logic              map_readable_reg;
    logic [HELD_W-1:0] scan_idx_reg;
    logic              rd_vld_reg;
    logic              found_reg;
    logic              out_valid_reg;

    logic [ADDR_W-1:0] q_addr_reg;
    logic [ADDR_W-1:0] rd_base_reg;
    logic [ADDR_W-1:0] rd_len_reg;
    logic [KIND_W-1:0] rd_kind_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [ADDR_W-1:0] best_base_reg;
    logic [ADDR_W-1:0] best_len_reg;
    logic [KIND_W-1:0] best_kind_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    rsp_word_t         pend_reg;
    rsp_word_t         pend_next;
    rsp_word_t         out_data_reg;

    logic load_zero;
    logic table_full;
    logic do_write;
    logic take_cand;
    logic in_span;

    // load decode
    assign load_zero  = (in_data.span_length == '0);
    assign table_full = (held_reg >= HELD_W'(MAX_SPANS));
    assign do_write   = cmd.capture && (in_data.req_type == REQ_LOAD) && !load_zero
                        && !table_full;

    // held count after the captured word
    always_comb
    begin
        held_next = held_reg;
        if (cmd.capture)
        begin
            if (in_data.req_type == REQ_CLEAR)
            begin
                held_next = '0;
            end
            else if (do_write)
            begin
                held_next = held_reg + HELD_W'(1);
            end
        end
    end

    // result of clear, load and other words; a query starts as a miss
    always_comb
    begin
        pend_next            = '0;
        pend_next.span_count = SPAN_COUNT_W'(held_next);
        if (in_data.req_type == REQ_LOAD)
        begin
            priority if (load_zero)
            begin
                pend_next.status = STATUS_ZERO;
            end
            else if (table_full)
            begin
                pend_next.status = STATUS_FULL;
            end
            else
            begin
                pend_next.span_index = SPAN_INDEX_W'(held_reg[SLOT_W-1:0]);
            end
        end
    end

    // candidate test and containment test
    assign take_cand = rd_vld_reg && (rd_base_reg <= q_addr_reg)
                       && (!found_reg || (rd_base_reg >= best_base_reg));
    assign in_span   = found_reg && ((q_addr_reg - best_base_reg) < best_len_reg);

    // status to the controller
    assign sts.query_go  = (in_data.req_type == REQ_QUERY) && map_readable_reg
                           && in_data.region_unnamed && (held_reg != '0);
    assign sts.scan_last = ((scan_idx_reg + HELD_W'(1)) == held_reg);
    assign sts.out_free  = !out_valid_reg || rsp.ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= '0;
            map_readable_reg <= 1'b1;
            scan_idx_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            if (cfg_we)
            begin
                map_readable_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + HELD_W'(1);
            end
            rd_vld_reg <= cmd.scan_step;
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (take_cand)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            base_mem[held_reg[SLOT_W-1:0]] <= in_data.address;
            len_mem[held_reg[SLOT_W-1:0]]  <= in_data.span_length;
            kind_mem[held_reg[SLOT_W-1:0]] <= classify(in_data.name_class, in_data.exec_perm);
        end
        if (cmd.scan_step)
        begin
            rd_base_reg <= base_mem[scan_idx_reg[SLOT_W-1:0]];
            rd_len_reg  <= len_mem[scan_idx_reg[SLOT_W-1:0]];
            rd_kind_reg <= kind_mem[scan_idx_reg[SLOT_W-1:0]];
            rd_slot_reg <= scan_idx_reg[SLOT_W-1:0];
        end
    end

    // query address, best candidate, pending result, output word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_addr_reg <= in_data.address;
            pend_reg   <= pend_next;
        end
        else if (cmd.finish && in_span)
        begin
            pend_reg.hit           <= 1'b1;
            pend_reg.kind          <= best_kind_reg;
            pend_reg.span_start    <= best_base_reg;
            pend_reg.extent_length <= best_len_reg;
            pend_reg.span_index    <= SPAN_INDEX_W'(best_slot_reg);
        end
        if (take_cand)
        begin
            best_base_reg <= rd_base_reg;
            best_len_reg  <= rd_len_reg;
            best_kind_reg <= rd_kind_reg;
            best_slot_reg <= rd_slot_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= pend_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // checks
    `ASC_ASSERT_ALWAYS(a_held_bound, clk, held_reg <= HELD_W'(MAX_SPANS),
        "held count above table size")
    `ASC_ASSERT(a_scan_in_table, clk, rst_n, cmd.scan_step |-> scan_idx_reg < held_reg,
        "scan past held spans")
    `ASC_ASSERT(a_hit_nonempty, clk, rst_n,
        (rsp.valid && rsp.data.hit) |-> (rsp.data.extent_length != '0)
            && (rsp.data.status == STATUS_OK),
        "hit on empty span")

endmodule

// ===== src/address_span_classifier_core.sv =====
// address span classifier
// req channel: one word per request, req_type selects clear, load or query.
// rsp channel: exactly one word per request, in request order.
// cfg_we/cfg_wdata write map_readable; write only while the block is idle.
// a clear or a load finishes in the cycle it is accepted and its reply word
// is loaded into the output register from the reply state once that register is free.
// a query that can hit scans the held spans through the table's single read
// port, one slot per cycle, then compares and checks containment in the
// drain and finish states before its reply.
// queries that cannot hit (map unreadable, named region, empty table) go
// straight to the reply state like a load.
// one request is in progress at a time; a new request is taken while the
// previous reply still sits in the output register.
// if the receiver stalls, the finished reply waits and the next request
// holds in its reply state until the output register drains.
// reset empties the table, sets map_readable to 1 and drops any word held.
module address_span_classifier_core (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    asc_req_if.sink   req,
    asc_rsp_if.source rsp
);
    import asc_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      in_ready;

    // sequencer
    asc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    assign req.ready = in_ready;

    // table, scan and result
    asc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (req.data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule

// ===== sim/tb_address_span_classifier_core.sv =====
module tb_address_span_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import asc_pkg::*;

    // request code that the block does not use, and a name class off the list
    localparam logic [1:0] REQ_SPARE     = 2'd3;
    localparam logic [2:0] NAME_UNLISTED = 3'd7;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;

    // span table predictor and reply checker
    class span_scoreboard;
        rsp_word_t         expect_q[$];
        logic [ADDR_W-1:0] base_mem[MAX_SPANS];
        logic [ADDR_W-1:0] len_mem[MAX_SPANS];
        logic [KIND_W-1:0] kind_mem[MAX_SPANS];
        int                held;
        bit                readable;
        int                mismatches;
        int                n_checked;
        int                n_words;
        int                n_hits;
        int                n_misses;
        int                n_stored;
        int                n_zero_drops;
        int                n_full_drops;

        function new();
            readable = 1'b1;
        endfunction

        function int pending();
            return expect_q.size();
        endfunction

        // kind from name class and execute bit
        function logic [KIND_W-1:0] span_kind(logic [2:0] nc, logic ex);
            case (nc)
                NAME_HEAP:  return KIND_HEAP;
                NAME_STACK: return KIND_STACK;
                NAME_FILE:  return ex ? KIND_CODE : KIND_DATA;
                default:    return KIND_MMAP;
            endcase
        endfunction

        // update the table for an accepted word and queue its reply
        function void note_request(req_word_t w);
            rsp_word_t r;
            int        best;
            bit        found;
            r     = '0;
            best  = 0;
            found = 1'b0;
            n_words++;
            case (w.req_type)
                REQ_CLEAR: held = 0;
                REQ_LOAD:
                begin
                    if (w.span_length == '0)
                    begin
                        r.status = STATUS_ZERO;
                        n_zero_drops++;
                    end
                    else if (held >= MAX_SPANS)
                    begin
                        r.status = STATUS_FULL;
                        n_full_drops++;
                    end
                    else
                    begin
                        base_mem[held] = w.address;
                        len_mem[held]  = w.span_length;
                        kind_mem[held] = span_kind(w.name_class, w.exec_perm);
                        r.span_index   = SPAN_INDEX_W'(held);
                        held++;
                        n_stored++;
                    end
                end
                REQ_QUERY:
                begin
                    if (readable && w.region_unnamed && held > 0)
                    begin
                        // greatest base at or below the address, later load wins ties
                        for (int i = 0; i < held; i++)
                        begin
                            if (base_mem[i] <= w.address &&
                                (!found || base_mem[i] >= base_mem[best]))
                            begin
                                best  = i;
                                found = 1'b1;
                            end
                        end
                        if (found && (w.address - base_mem[best]) < len_mem[best])
                        begin
                            r.hit           = 1'b1;
                            r.kind          = kind_mem[best];
                            r.span_start    = base_mem[best];
                            r.extent_length = len_mem[best];
                            r.span_index    = SPAN_INDEX_W'(best);
                        end
                    end
                    if (r.hit)
                        n_hits++;
                    else
                        n_misses++;
                end
                default: ;
            endcase
            r.span_count = SPAN_COUNT_W'(held);
            expect_q.insert(expect_q.size(), r);
        endfunction

        // compare a reply word with the oldest expected one
        function void check_reply(rsp_word_t got);
            rsp_word_t e;
            n_checked++;
            if (expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply %0d arrived with nothing outstanding: hit %0d index %0d",
                             n_checked, got.hit, got.span_index);
                return;
            end
            e = expect_q.pop_front();
            if (got.hit !== e.hit || got.kind !== e.kind ||
                got.span_start !== e.span_start || got.extent_length !== e.extent_length ||
                got.span_index !== e.span_index || got.status !== e.status ||
                got.span_count !== e.span_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch on reply %0d", n_checked);
                    $display("  expected hit %0d kind %0d base %h length %h", e.hit, e.kind,
                             e.span_start, e.extent_length);
                    $display("           index %0d status %0d count %0d", e.span_index,
                             e.status, e.span_count);
                    $display("  actual   hit %0d kind %0d base %h length %h", got.hit,
                             got.kind, got.span_start, got.extent_length);
                    $display("           index %0d status %0d count %0d", got.span_index,
                             got.status, got.span_count);
                end
            end
        endfunction
    endclass

    typedef struct {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
    } span_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    asc_req_if req_ch ();
    asc_rsp_if rsp_ch ();

    span_scoreboard sb;
    span_t          gen_spans[$];
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             hold_off;
    int             quiet_cycles;

    address_span_classifier_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watch both channels at the rising edge, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_reply(rsp_ch.data);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("tb_address_span_classifier_core failed");
                $finish;
            end
        end
    end

    // reply side ready, random stalls and one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(negedge clk);
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // span bases cluster in a few windows so that they overlap and tie
    function automatic logic [ADDR_W-1:0] pick_base();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 9))
            0:       a = rand64();
            1:       a = 64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(0, 4095));
            2:       a = 64'($urandom_range(0, 4095));
            default: a = 64'h0000_5555_0000_0000 + 64'($urandom_range(0, 4095));
        endcase
        if (gen_spans.size() != 0 && $urandom_range(0, 6) == 0)
            a = gen_spans[$urandom_range(0, gen_spans.size() - 1)].base;
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return rand64();
        else if (r < 12)
            return '1;
        return 64'($urandom_range(1, 600));
    endfunction

    // query addresses mostly land in a loaded span or next to its edges
    function automatic logic [ADDR_W-1:0] pick_query_address();
        span_t s;
        if (gen_spans.size() == 0 || $urandom_range(0, 99) >= 75)
            return pick_base();
        s = gen_spans[$urandom_range(0, gen_spans.size() - 1)];
        case ($urandom_range(0, 5))
            0:       return s.base;
            1:       return s.base + s.len - 64'd1;
            2:       return s.base + s.len;
            3:       return s.base - 64'd1;
            default: return s.base + (rand64() % s.len);
        endcase
    endfunction

    function automatic req_word_t make_word(input logic [1:0] rt);
        req_word_t w;
        w.req_type       = rt;
        w.address        = rand64();
        w.span_length    = rand64();
        w.name_class     = 3'($urandom_range(0, 7));
        w.exec_perm      = 1'($urandom_range(0, 1));
        w.region_unnamed = 1'($urandom_range(0, 1));
        case (rt)
            REQ_LOAD:
            begin
                w.address     = pick_base();
                w.span_length = pick_length();
            end
            REQ_QUERY:
            begin
                w.address        = pick_query_address();
                w.region_unnamed = ($urandom_range(0, 9) != 0);
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic req_word_t span_load(input logic [ADDR_W-1:0] base,
                                            input logic [ADDR_W-1:0] len,
                                            input logic [2:0] nc, input logic ex);
        req_word_t w;
        w = '0;
        w.req_type    = REQ_LOAD;
        w.address     = base;
        w.span_length = len;
        w.name_class  = nc;
        w.exec_perm   = ex;
        return w;
    endfunction

    function automatic req_word_t addr_query(input logic [ADDR_W-1:0] addr,
                                             input logic unnamed);
        req_word_t w;
        w = '0;
        w.req_type       = REQ_QUERY;
        w.address        = addr;
        w.region_unnamed = unnamed;
        return w;
    endfunction

    // offer one word; entered and left just after a falling edge, valid stays high
    task automatic send_word(input req_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // track loaded spans for aiming queries, then send
    task automatic issue(input req_word_t w);
        if (w.req_type == REQ_CLEAR)
            gen_spans.delete();
        else if (w.req_type == REQ_LOAD && w.span_length != '0 &&
                 gen_spans.size() < MAX_SPANS)
            gen_spans.insert(gen_spans.size(), '{w.address, w.span_length});
        send_word(w);
    endtask

    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // register write only with the block idle
    task automatic set_map_readable(input bit v);
        wait_for_replies();
        repeat (4) @(negedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.readable = v;
    endtask

    // clear, then load past the table size so the last loads are dropped
    task automatic fill_table();
        req_word_t w;
        issue(make_word(REQ_CLEAR));
        repeat (MAX_SPANS + 3)
        begin
            w = make_word(REQ_LOAD);
            if (w.span_length == '0)
                w.span_length = 64'($urandom_range(1, 600));
            issue(w);
        end
    endtask

    task automatic run_directed();
        req_word_t w;
        issue(addr_query(64'h0, 1'b1));
        issue(span_load(64'h1000, 64'h0, NAME_HEAP, 1'b0));
        issue(span_load(64'h1000, 64'h100, NAME_STACK, 1'b0));
        // nothing at or below the address
        issue(addr_query(64'h10, 1'b1));
        // same base again, the later span must win
        issue(span_load(64'h1000, 64'h10, NAME_PSEUDO, 1'b1));
        issue(span_load(64'h0, 64'h1, NAME_HEAP, 1'b1));
        // extent end past 2^64
        issue(span_load(64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, NAME_FILE, 1'b1));
        issue(span_load(64'h2000, 64'h80, NAME_FILE, 1'b0));
        issue(span_load(64'h3000, 64'h40, NAME_EMPTY, 1'b0));
        issue(span_load(64'h4000, 64'h40, NAME_UNLISTED, 1'b1));
        issue(addr_query(64'h0, 1'b1));
        issue(addr_query(64'h1, 1'b1));
        issue(addr_query(64'h100F, 1'b1));
        // chosen span misses, the wider earlier one is not tried
        issue(addr_query(64'h1010, 1'b1));
        issue(addr_query(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        issue(addr_query(64'h207F, 1'b1));
        issue(addr_query(64'h2080, 1'b1));
        issue(addr_query(64'h3000, 1'b1));
        issue(addr_query(64'h403F, 1'b1));
        // named region never hits
        issue(addr_query(64'h2000, 1'b0));
        w = addr_query(64'h2000, 1'b1);
        w.req_type = REQ_SPARE;
        issue(w);
        w.req_type = REQ_CLEAR;
        issue(w);
        issue(addr_query(64'h2000, 1'b1));
        issue(span_load(64'h5000, 64'h8, NAME_STACK, 1'b0));
    endtask

    // random mix with one full-table pass halfway through longer runs
    task automatic run_random(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            if (count >= 300 && n == count / 2)
                fill_table();
            r = $urandom_range(0, 99);
            if (r < 3)
                issue(make_word(REQ_CLEAR));
            else if (r < 5)
                issue(make_word(REQ_SPARE));
            else if (r < 50)
                issue(make_word(REQ_LOAD));
            else
                issue(make_word(REQ_QUERY));
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        send_idle_pct = 37;
        recv_idle_pct = 80;
        hold_off      = 1'b0;
        quiet_cycles  = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sender sparse, receiver mostly stalled
        run_directed();
        run_random(400);
        set_map_readable(1'b0);
        run_random(120);
        set_map_readable(1'b1);

        // sender mostly idle, receiver sparse, with one full pause
        send_idle_pct = 80;
        recv_idle_pct = 37;
        run_random(400);
        wait_for_replies();
        run_random(50);

        // back to back, then a long reply hold-off while words keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_map_readable(1'b0);
        run_random(100);
        set_map_readable(1'b1);
        run_random(200);
        hold_off = 1'b1;
        run_random(300);

        // drain and settle
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d words with the map readable and unreadable, %s", sb.n_words,
                 "three idle mixes, a full table and a long reply stall");
        $display("summary: %0d hits, %0d misses, %0d spans stored, %0d zero-length and %0d full-table drops",
                 sb.n_hits, sb.n_misses, sb.n_stored, sb.n_zero_drops, sb.n_full_drops);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_address_span_classifier_core passed");
        else
            $display("tb_address_span_classifier_core failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/asc_pkg.sv
src/asc_req_if.sv
src/asc_rsp_if.sv
src/asc_ctrl.sv
src/asc_datapath.sv
src/address_span_classifier_core.sv
sim/tb_address_span_classifier_core.sv
